// File: hdl/earx_pkg.sv
package earx_pkg;

  localparam int unsigned MacW  = 48;
  localparam int unsigned IpW   = 32;
  localparam int unsigned PosW  = 6;
  localparam int unsigned OutDW = 256;

  localparam logic [7:0] EthTypeHi  = 8'h08;
  localparam logic [7:0] EthTypeArp = 8'h06;
  localparam logic [7:0] IpVerIhl   = 8'h45;
  localparam logic [7:0] ByteOnes   = 8'hff;
  localparam logic [7:0] ProtoIcmp  = 8'd1;
  localparam logic [7:0] ProtoUdp   = 8'd17;
  localparam logic [7:0] IcmpEchoRq = 8'd8;
  localparam logic [7:0] IcmpEchoRp = 8'd0;
  localparam logic [15:0] ArpOpReq  = 16'd1;
  localparam logic [15:0] ArpOpRep  = 16'd2;

  localparam logic [1:0] CfgMyMac  = 2'd0;
  localparam logic [1:0] CfgMyIp   = 2'd1;
  localparam logic [1:0] CfgMyMask = 2'd2;

  typedef enum logic [3:0] {
    V_RUNT       = 4'd0,
    V_NOT_ETH    = 4'd1,
    V_ARP_REQ    = 4'd2,
    V_ARP_REPLY  = 4'd3,
    V_ARP_IGN    = 4'd4,
    V_NOT_IP     = 4'd5,
    V_NOT_ME     = 4'd6,
    V_ECHO_REQ   = 4'd7,
    V_ECHO_REPLY = 4'd8,
    V_ICMP_OTHER = 4'd9,
    V_UDP        = 4'd10,
    V_OTHER      = 4'd11,
    V_TRUNC      = 4'd12
  } verdict_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ARP  = 2'd1,
    KIND_IP   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [15:0]    arp_protocol;
    logic [IpW-1:0] arp_sender_ip;
    logic [MacW-1:0] arp_sender_mac;
    logic [15:0]    icmp_sequence;
    logic [15:0]    icmp_ident;
    logic [15:0]    local_port;
    logic [15:0]    remote_port;
    logic [15:0]    ip_total_length;
    logic [IpW-1:0] src_ip;
    logic [MacW-1:0] src_mac;
  } fields_t;

  typedef struct packed {
    verdict_t verdict;
    fields_t  fields;
  } result_t;

endpackage

// File: hdl/eth_arp_ip_rx_classifier_top.sv
// Channel | Direction | Handshake            | Payload
// in_     | slave     | in_tvalid/in_tready  | tdata[7:0] data_byte, tlast last_byte
// out_    | master    | out_tvalid/out_tready| tuser[3:0] verdict, tdata[255:0] fields
// cfg_    | write     | cfg_we               | cfg_index, cfg_wdata[47:0]
//
// One byte per clock, save where a stalled result holds up a last byte; the last byte
// goes into the input register, then its verdict into the result register after the header decode.
// Synchronous active-low reset clears frame state and station registers.
// A stalled result only holds up the input stage when a further last byte
// reaches it; ordinary bytes keep flowing under output back-pressure.
module eth_arp_ip_rx_classifier_top import earx_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] data_byte
  input  logic             in_tlast,   // last_byte
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [3:0]       out_tuser,  // [3:0] verdict
  // [47:0] src_mac, [79:48] src_ip, [95:80] ip_total_length,
  // [111:96] remote_port, [127:112] local_port, [143:128] icmp_ident,
  // [159:144] icmp_sequence, [207:160] arp_sender_mac,
  // [239:208] arp_sender_ip, [255:240] arp_protocol
  output logic [OutDW-1:0] out_tdata,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [MacW-1:0]  cfg_wdata
);

  logic            in_v_r;
  logic [7:0]      in_byte_r;
  logic            in_last_r;
  logic            out_v_r;
  result_t         out_r;
  logic            advance;
  result_t         result;
  logic [MacW-1:0] my_mac_r;
  logic [IpW-1:0]  my_ip_r;
  logic [IpW-1:0]  my_mask_r;

  assign advance   = in_v_r && (!in_last_r || !out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_mac_r  <= '0;
      my_ip_r   <= '0;
      my_mask_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgMyMac:  my_mac_r  <= cfg_wdata;
        CfgMyIp:   my_ip_r   <= cfg_wdata[IpW-1:0];
        CfgMyMask: my_mask_r <= cfg_wdata[IpW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  earx_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (in_byte_r),
    .last_byte (in_last_r),
    .my_mac    (my_mac_r),
    .my_ip     (my_ip_r),
    .my_mask   (my_mask_r),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.verdict;
  assign out_tdata  = out_r.fields;

endmodule

// File: hdl/earx_parser.sv
module earx_parser import earx_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  logic [MacW-1:0]  my_mac,
  input  logic [IpW-1:0]   my_ip,
  input  logic [IpW-1:0]   my_mask,
  output result_t          result
);

  logic [PosW-1:0] pos_r, pos_nxt;
  kind_t           kind_r, kind_nxt;
  verdict_t        early_r, early_nxt;
  logic            decided_r, decided_nxt;
  logic            match_r, match_nxt;
  logic [7:0]      proto_r, proto_nxt;
  logic [15:0]     opcode_r, opcode_nxt;
  logic [31:0]     ports_r, ports_nxt;
  fields_t         fld_r, fld_nxt;

  logic            capture;
  logic            dec_req;
  verdict_t        dec_val;
  logic [2:0]      mac_idx;
  logic [1:0]      ip_idx;
  logic [1:0]      dst_idx;
  logic [7:0]      mac_b, ip_b, dst_ip_b, dst_inv_b;
  logic [15:0]     opcode_sh;
  logic            dst_ok;

  assign capture = !decided_r || early_r == V_NOT_ME || early_r == V_ECHO_REQ ||
                   early_r == V_ECHO_REPLY || early_r == V_ICMP_OTHER;

  // byte lanes of the station addresses, most significant first on the wire
  assign mac_idx   = 3'(6'd37 - pos_r);
  assign ip_idx    = 2'(6'd41 - pos_r);
  assign dst_idx   = 2'(6'd33 - pos_r);
  assign mac_b     = my_mac[{mac_idx, 3'b000} +: 8];
  assign ip_b      = my_ip[{ip_idx, 3'b000} +: 8];
  assign dst_ip_b  = my_ip[{dst_idx, 3'b000} +: 8];
  assign dst_inv_b = ~my_mask[{dst_idx, 3'b000} +: 8];
  assign dst_ok    = (data_byte == dst_ip_b) || ((data_byte & dst_inv_b) == ByteOnes);
  assign opcode_sh = {opcode_r[7:0], data_byte};

  always_comb begin
    kind_nxt   = kind_r;
    match_nxt  = match_r;
    proto_nxt  = proto_r;
    opcode_nxt = opcode_r;
    ports_nxt  = ports_r;
    fld_nxt    = fld_r;
    dec_req    = 1'b0;
    dec_val    = V_RUNT;

    if (pos_r >= 6'd6 && pos_r <= 6'd11) begin
      fld_nxt.src_mac = {fld_r.src_mac[MacW-9:0], data_byte};
    end else if (pos_r == 6'd12) begin
      if (data_byte != EthTypeHi) begin
        dec_req = 1'b1;
        dec_val = V_NOT_ETH;
      end
    end else if (pos_r == 6'd13) begin
      if (!decided_r) begin
        kind_nxt = (data_byte == EthTypeArp) ? KIND_ARP : KIND_IP;
      end
    end else if (capture && kind_r == KIND_ARP) begin
      if (pos_r == 6'd16 || pos_r == 6'd17) begin
        fld_nxt.arp_protocol = {fld_r.arp_protocol[7:0], data_byte};
      end else if (pos_r == 6'd20 || pos_r == 6'd21) begin
        opcode_nxt = opcode_sh;
        if (pos_r == 6'd21 && opcode_sh != ArpOpReq && opcode_sh != ArpOpRep) begin
          dec_req = 1'b1;
          dec_val = V_ARP_IGN;
        end
      end else if (pos_r >= 6'd22 && pos_r <= 6'd27) begin
        fld_nxt.arp_sender_mac = {fld_r.arp_sender_mac[MacW-9:0], data_byte};
      end else if (pos_r >= 6'd28 && pos_r <= 6'd31) begin
        fld_nxt.arp_sender_ip = {fld_r.arp_sender_ip[IpW-9:0], data_byte};
      end else if (pos_r >= 6'd32 && pos_r <= 6'd37 && opcode_r == ArpOpRep) begin
        match_nxt = match_r && (mac_b == data_byte);
        if (pos_r == 6'd37) begin
          dec_req = 1'b1;
          dec_val = match_nxt ? V_ARP_REPLY : V_ARP_IGN;
        end
      end else if (pos_r >= 6'd38 && pos_r <= 6'd41 && opcode_r == ArpOpReq) begin
        match_nxt = match_r && (ip_b == data_byte);
        if (pos_r == 6'd41) begin
          dec_req = 1'b1;
          dec_val = match_nxt ? V_ARP_REQ : V_ARP_IGN;
        end
      end
    end else if (capture && kind_r == KIND_IP) begin
      if (pos_r == 6'd14) begin
        if (data_byte != IpVerIhl) begin
          dec_req = 1'b1;
          dec_val = V_NOT_IP;
        end
      end else if (pos_r == 6'd16 || pos_r == 6'd17) begin
        fld_nxt.ip_total_length = {fld_r.ip_total_length[7:0], data_byte};
      end else if (pos_r == 6'd23) begin
        proto_nxt = data_byte;
      end else if (pos_r >= 6'd26 && pos_r <= 6'd29) begin
        fld_nxt.src_ip = {fld_r.src_ip[IpW-9:0], data_byte};
      end else if (pos_r >= 6'd30 && pos_r <= 6'd33) begin
        match_nxt = match_r && dst_ok;
        if (pos_r == 6'd33) begin
          if (!match_nxt) begin
            dec_req = 1'b1;
            dec_val = V_NOT_ME;
          end else if (proto_r != ProtoIcmp && proto_r != ProtoUdp) begin
            dec_req = 1'b1;
            dec_val = V_OTHER;
          end
        end
      end else if (pos_r >= 6'd34 && pos_r <= 6'd37 && proto_r == ProtoUdp) begin
        // ports are kept even when the destination missed
        ports_nxt = {ports_r[23:0], data_byte};
        if (pos_r == 6'd37 && match_r) begin
          dec_req = 1'b1;
          dec_val = V_UDP;
        end
      end else if (pos_r >= 6'd34 && pos_r <= 6'd41 && proto_r == ProtoIcmp && match_r) begin
        if (pos_r == 6'd34) begin
          dec_req = 1'b1;
          dec_val = (data_byte == IcmpEchoRp) ? V_ECHO_REPLY :
                    (data_byte == IcmpEchoRq) ? V_ECHO_REQ : V_ICMP_OTHER;
        end else if (pos_r == 6'd38 || pos_r == 6'd39) begin
          fld_nxt.icmp_ident = {fld_r.icmp_ident[7:0], data_byte};
        end else if (pos_r == 6'd40 || pos_r == 6'd41) begin
          fld_nxt.icmp_sequence = {fld_r.icmp_sequence[7:0], data_byte};
        end
      end
    end

    fld_nxt.remote_port = ports_nxt[31:16];
    fld_nxt.local_port  = ports_nxt[15:0];

    // first decision of the frame sticks
    decided_nxt = decided_r || dec_req;
    early_nxt   = (!decided_r && dec_req) ? dec_val : early_r;
    pos_nxt     = (pos_r == {PosW{1'b1}}) ? pos_r : pos_r + 1'b1;
  end

  // result as seen after this byte; only meaningful on the last byte
  always_comb begin
    if (pos_r < 6'd7) begin
      result.verdict = V_RUNT;
      result.fields  = '0;
    end else begin
      result.verdict = decided_nxt ? early_nxt : V_TRUNC;
      result.fields  = fld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      kind_r    <= KIND_NONE;
      early_r   <= V_RUNT;
      decided_r <= 1'b0;
      match_r   <= 1'b1;
      proto_r   <= '0;
      opcode_r  <= '0;
      ports_r   <= '0;
      fld_r     <= '0;
    end else if (step) begin
      if (last_byte) begin
        pos_r     <= '0;
        kind_r    <= KIND_NONE;
        early_r   <= V_RUNT;
        decided_r <= 1'b0;
        match_r   <= 1'b1;
        proto_r   <= '0;
        opcode_r  <= '0;
        ports_r   <= '0;
        fld_r     <= '0;
      end else begin
        pos_r     <= pos_nxt;
        kind_r    <= kind_nxt;
        early_r   <= early_nxt;
        decided_r <= decided_nxt;
        match_r   <= match_nxt;
        proto_r   <= proto_nxt;
        opcode_r  <= opcode_nxt;
        ports_r   <= ports_nxt;
        fld_r     <= fld_nxt;
      end
    end
  end

endmodule
